// File: hw/rtl/modular_exponentiation_top_defines.svh
// ----------------------------------------------------------------------------
// Modular exponentiation assertion macros
// Shared concurrent assertion forms; define ASSERT_OFF to drop them all.
// ----------------------------------------------------------------------------
`ifndef MODULAR_EXPONENTIATION_TOP_DEFINES_SVH
`define MODULAR_EXPONENTIATION_TOP_DEFINES_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("modexp assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("modexp assertion failed");

`else

`define ASSERT_IMPLIES(label, clk, rst, pre, post)
`define ASSERT_NEXT(label, clk, rst, pre, post)

`endif

`endif

// File: hw/rtl/modexp_pkg.sv
// ----------------------------------------------------------------------------
// Modular exponentiation package
// Shared types and register codes for the modular exponentiation block.
// ----------------------------------------------------------------------------
`default_nettype none

package modexp_pkg;

   // configuration register index
   localparam int CSR_INDEX_WIDTH = 2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_EXPONENT = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MODULUS  = 2'd1;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_SQUARE,
      ST_MULTIPLY,
      ST_DELIVER
   } state_type;

   // status of a bit-serial arithmetic unit
   typedef struct packed {
      logic busy;
      logic done;
   } unit_status_type;

endpackage

`default_nettype wire

// File: hw/rtl/modular_exponentiation_top.sv
// ----------------------------------------------------------------------------
// Modular exponentiation top level
// Computes base^exponent mod modulus for each input word (RSA core).
// ----------------------------------------------------------------------------
// Each req word carries one base value; one rsp word returns
// base^exponent mod modulus. Exponent and modulus are csr registers (index 0
// and 1, reset 1 and 2), to be written by the user only while the block is
// idle, which the block itself does not enforce; other indexes are ignored.
// A modulus below 2 returns 0. The base is first reduced mod the modulus by
// a bit-serial restoring divider, then the exponent is scanned MSB first over
// all WIDTH bits: every bit costs one modular squaring, and every set bit one
// more modular multiply, each done by a single shift-and-add multiplier that
// consumes one multiplier bit per cycle. One item is in flight at a time; the
// result sits in an output register, so the next base is accepted while it
// waits.
// ----------------------------------------------------------------------------
`default_nettype none
`include "modular_exponentiation_top_defines.svh"

module modular_exponentiation_top #(
   parameter int WIDTH = 20
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   // input words
   input  wire logic                                   req_valid,
   output      logic                                   req_ready,
   input  wire logic [WIDTH-1:0]                       req_base_value,
   // result words
   output      logic                                   rsp_valid,
   input  wire logic                                   rsp_ready,
   output      logic [WIDTH-1:0]                       rsp_result_value,
   // register writes
   input  wire logic                                   csr_valid,
   output      logic                                   csr_ready,
   input  wire logic [modexp_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [WIDTH-1:0]                       csr_data
);

   localparam int CNT_WIDTH = $clog2(WIDTH);

   // configuration
   logic [WIDTH-1:0]            exponent_ff;
   logic [WIDTH-1:0]            modulus_ff;

   // sequencer
   modexp_pkg::state_type       state_ff, state_in;
   logic                        launch_ff, launch_in;
   logic [WIDTH-1:0]            acc_ff, acc_in;        // running power
   logic [WIDTH-1:0]            base_ff, base_in;      // reduced base
   logic [WIDTH-1:0]            exp_ff, exp_in;        // exponent, MSB next
   logic [CNT_WIDTH-1:0]        bit_cnt_ff, bit_cnt_in;

   // output register
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [WIDTH-1:0]            rsp_value_ff, rsp_value_in;

   // arithmetic units
   modexp_pkg::unit_status_type mm_status;
   modexp_pkg::unit_status_type rd_status;
   logic [WIDTH-1:0]            mm_a;
   logic [WIDTH-1:0]            mm_product;
   logic [WIDTH-1:0]            rd_remainder;
   logic                        mm_start;
   logic                        rd_start;

   logic                        req_take;
   logic                        slot_free;
   logic                        mod_small;
   logic                        last_bit;
   logic                        launch_state;

   assign csr_ready = 1'b1;
   assign req_ready = (state_ff == modexp_pkg::ST_IDLE);
   assign req_take  = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign mod_small = (modulus_ff < WIDTH'(2));
   assign last_bit  = (bit_cnt_ff == '0);

   // ---------------------------------------------------------------- config
   always_ff @(posedge clock) begin
      if (reset) begin
         exponent_ff <= {{(WIDTH-1){1'b0}}, 1'b1};
         modulus_ff  <= WIDTH'(2);
      end else if (csr_valid && csr_ready) begin
         if (csr_index == modexp_pkg::CSR_EXPONENT) begin
            exponent_ff <= csr_data;
         end else if (csr_index == modexp_pkg::CSR_MODULUS) begin
            modulus_ff <= csr_data;
         end
      end
   end

   // ---------------------------------------------------------------- units
   // square uses acc twice; multiply step uses acc and the reduced base
   assign mm_a     = (state_ff == modexp_pkg::ST_MULTIPLY) ? base_ff : acc_ff;
   assign mm_start = launch_ff && (state_ff != modexp_pkg::ST_REDUCE);
   assign rd_start = launch_ff && (state_ff == modexp_pkg::ST_REDUCE);

   modexp_mulmod #(
      .WIDTH   (WIDTH)
   ) u_mulmod (
      .clock   (clock),
      .reset   (reset),
      .start   (mm_start),
      .a_value (mm_a),
      .b_value (acc_ff),
      .m_value (modulus_ff),
      .product (mm_product),
      .status  (mm_status)
   );

   modexp_reduce #(
      .WIDTH     (WIDTH)
   ) u_reduce (
      .clock     (clock),
      .reset     (reset),
      .start     (rd_start),
      .value     (base_ff),
      .m_value   (modulus_ff),
      .remainder (rd_remainder),
      .status    (rd_status)
   );

   // ---------------------------------------------------------------- next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         modexp_pkg::ST_IDLE: begin
            if (req_take) begin
               state_in = mod_small ? modexp_pkg::ST_DELIVER : modexp_pkg::ST_REDUCE;
            end
         end
         modexp_pkg::ST_REDUCE: begin
            if (rd_status.done) begin
               state_in = modexp_pkg::ST_SQUARE;
            end
         end
         modexp_pkg::ST_SQUARE: begin
            if (mm_status.done) begin
               if (exp_ff[WIDTH-1]) begin
                  state_in = modexp_pkg::ST_MULTIPLY;
               end else if (last_bit) begin
                  state_in = modexp_pkg::ST_DELIVER;
               end
            end
         end
         modexp_pkg::ST_MULTIPLY: begin
            if (mm_status.done) begin
               state_in = last_bit ? modexp_pkg::ST_DELIVER : modexp_pkg::ST_SQUARE;
            end
         end
         modexp_pkg::ST_DELIVER: begin
            if (slot_free) begin
               state_in = modexp_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = modexp_pkg::ST_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------- datapath
   // a unit is started on entry to its state, and again on each new squaring
   assign launch_state = (state_in == modexp_pkg::ST_REDUCE) ||
                         (state_in == modexp_pkg::ST_SQUARE) ||
                         (state_in == modexp_pkg::ST_MULTIPLY);

   always_comb begin
      launch_in    = launch_state && ((state_in != state_ff) || mm_status.done);
      acc_in       = acc_ff;
      base_in      = base_ff;
      exp_in       = exp_ff;
      bit_cnt_in   = bit_cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_value_in = rsp_value_ff;
      case (state_ff)
         modexp_pkg::ST_IDLE: begin
            if (req_take) begin
               base_in    = req_base_value;
               exp_in     = exponent_ff;
               bit_cnt_in = CNT_WIDTH'(WIDTH - 1);
               acc_in     = mod_small ? '0 : {{(WIDTH-1){1'b0}}, 1'b1};
            end
         end
         modexp_pkg::ST_REDUCE: begin
            if (rd_status.done) begin
               base_in = rd_remainder;
            end
         end
         modexp_pkg::ST_SQUARE: begin
            if (mm_status.done) begin
               acc_in = mm_product;
               // shift the exponent only when its bit is clear: such a bit is finished after the squaring
               if (!exp_ff[WIDTH-1]) begin
                  exp_in     = {exp_ff[WIDTH-2:0], 1'b0};
                  bit_cnt_in = bit_cnt_ff - 1'b1;
               end
            end
         end
         modexp_pkg::ST_MULTIPLY: begin
            if (mm_status.done) begin
               acc_in     = mm_product;
               exp_in     = {exp_ff[WIDTH-2:0], 1'b0};
               bit_cnt_in = bit_cnt_ff - 1'b1;
            end
         end
         modexp_pkg::ST_DELIVER: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = acc_ff;
            end
         end
         default: begin
            launch_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= modexp_pkg::ST_IDLE;
         launch_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         launch_ff    <= launch_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      acc_ff       <= acc_in;
      base_ff      <= base_in;
      exp_ff       <= exp_in;
      bit_cnt_ff   <= bit_cnt_in;
      rsp_value_ff <= rsp_value_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_value_ff;

   `ASSERT_NEXT(a_accept_leaves_idle, clock, reset, req_take, state_ff != modexp_pkg::ST_IDLE)
   `ASSERT_IMPLIES(a_mm_done_in_loop, clock, reset, mm_status.done,
      (state_ff == modexp_pkg::ST_SQUARE) || (state_ff == modexp_pkg::ST_MULTIPLY))
   `ASSERT_IMPLIES(a_acc_reduced, clock, reset,
      (state_ff == modexp_pkg::ST_SQUARE) || (state_ff == modexp_pkg::ST_MULTIPLY),
      acc_ff < modulus_ff)
   `ASSERT_IMPLIES(a_one_unit_busy, clock, reset, rd_status.busy, !mm_status.busy)

endmodule

`default_nettype wire

// File: hw/rtl/modexp_mulmod.sv
// ----------------------------------------------------------------------------
// Bit-serial modular multiplier
// Shift-and-add (a * b) mod m, one multiplier bit per cycle, MSB first.
// ----------------------------------------------------------------------------
`default_nettype none
`include "modular_exponentiation_top_defines.svh"

module modexp_mulmod #(
   parameter int WIDTH = 20
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [WIDTH-1:0]              a_value,
   input  wire logic [WIDTH-1:0]              b_value,
   input  wire logic [WIDTH-1:0]              m_value,
   output      logic [WIDTH-1:0]              product,
   output      modexp_pkg::unit_status_type   status
);

   localparam int CNT_WIDTH = $clog2(WIDTH);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic [WIDTH-1:0]     acc_ff, acc_in;
   logic [WIDTH-1:0]     opa_ff, opa_in;
   logic [WIDTH-1:0]     opb_ff, opb_in;
   logic [WIDTH-1:0]     mod_ff, mod_in;

   logic [WIDTH:0]       mod_ext;
   logic [WIDTH:0]       dbl;
   logic [WIDTH:0]       dbl_red;
   logic [WIDTH:0]       sum;
   logic [WIDTH:0]       sum_red;
   logic                 last_bit;

   // acc = 2*acc mod m, then + a mod m when the current b bit is set
   always_comb begin
      mod_ext = {1'b0, mod_ff};
      dbl     = {acc_ff, 1'b0};
      dbl_red = (dbl >= mod_ext) ? (dbl - mod_ext) : dbl;
      sum     = {1'b0, dbl_red[WIDTH-1:0]} + (opb_ff[WIDTH-1] ? {1'b0, opa_ff} : '0);
      sum_red = (sum >= mod_ext) ? (sum - mod_ext) : sum;
   end

   assign last_bit = busy_ff && (cnt_ff == '0);

   always_comb begin
      busy_in = busy_ff;
      done_in = last_bit;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      opa_in  = opa_ff;
      opb_in  = opb_ff;
      mod_in  = mod_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_WIDTH'(WIDTH - 1);
         acc_in  = '0;
         opa_in  = a_value;
         opb_in  = b_value;
         mod_in  = m_value;
      end else if (busy_ff) begin
         acc_in = sum_red[WIDTH-1:0];
         opb_in = {opb_ff[WIDTH-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (last_bit) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      acc_ff <= acc_in;
      opa_ff <= opa_in;
      opb_ff <= opb_in;
      mod_ff <= mod_in;
   end

   assign product     = acc_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

   `ASSERT_IMPLIES(a_mm_start_idle, clock, reset, start, !busy_ff)
   `ASSERT_IMPLIES(a_mm_acc_reduced, clock, reset, busy_ff, acc_ff < mod_ff)
   `ASSERT_NEXT(a_mm_done_after_last, clock, reset, last_bit, done_ff && !busy_ff)

endmodule

`default_nettype wire

// File: hw/rtl/modexp_reduce.sv
// ----------------------------------------------------------------------------
// Bit-serial modular reduction
// Restoring remainder value mod m, one dividend bit per cycle, MSB first.
// ----------------------------------------------------------------------------
`default_nettype none
`include "modular_exponentiation_top_defines.svh"

module modexp_reduce #(
   parameter int WIDTH = 20
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [WIDTH-1:0]              value,
   input  wire logic [WIDTH-1:0]              m_value,
   output      logic [WIDTH-1:0]              remainder,
   output      modexp_pkg::unit_status_type   status
);

   localparam int CNT_WIDTH = $clog2(WIDTH);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic [WIDTH-1:0]     rem_ff, rem_in;
   logic [WIDTH-1:0]     val_ff, val_in;
   logic [WIDTH-1:0]     mod_ff, mod_in;

   logic [WIDTH:0]       mod_ext;
   logic [WIDTH:0]       trial;
   logic [WIDTH:0]       trial_red;
   logic                 last_bit;

   always_comb begin
      mod_ext   = {1'b0, mod_ff};
      trial     = {rem_ff, val_ff[WIDTH-1]};
      trial_red = (trial >= mod_ext) ? (trial - mod_ext) : trial;
   end

   assign last_bit = busy_ff && (cnt_ff == '0);

   always_comb begin
      busy_in = busy_ff;
      done_in = last_bit;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      val_in  = val_ff;
      mod_in  = mod_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_WIDTH'(WIDTH - 1);
         rem_in  = '0;
         val_in  = value;
         mod_in  = m_value;
      end else if (busy_ff) begin
         rem_in = trial_red[WIDTH-1:0];
         val_in = {val_ff[WIDTH-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (last_bit) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      val_ff <= val_in;
      mod_ff <= mod_in;
   end

   assign remainder   = rem_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

   `ASSERT_IMPLIES(a_rd_start_idle, clock, reset, start, !busy_ff)
   `ASSERT_IMPLIES(a_rd_rem_reduced, clock, reset, busy_ff, rem_ff < mod_ff)
   `ASSERT_NEXT(a_rd_done_after_last, clock, reset, last_bit, done_ff && !busy_ff)

endmodule

`default_nettype wire

// File: bench/modular_exponentiation_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Modular exponentiation testbench
// Runs a directed table, then random phases that each set a new exponent and
// modulus. Every accepted base value is predicted in the bench and checked
// against the returned word, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------

module modular_exponentiation_top_tb;

   localparam int WIDTH = 20;
   localparam int unsigned MAX_VALUE = (1 << WIDTH) - 1;
   // indexes that decode to no register; writes to them must be dropped
   localparam logic [modexp_pkg::CSR_INDEX_WIDTH-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [modexp_pkg::CSR_INDEX_WIDTH-1:0] CSR_SPARE_B = 2'd3;
   // run and drain bounds, in clock cycles
   localparam int unsigned CYCLE_LIMIT = 4_000_000;
   localparam int unsigned DRAIN_CYCLES = 1000;
   localparam int unsigned RANDOM_PHASES = 30;
   localparam int unsigned WORDS_PER_PHASE = 25;

   typedef logic [WIDTH-1:0] word_type;

   // one row of the directed table: a register write or a base word
   typedef enum logic {
      ROW_WRITE,
      ROW_BASE
   } row_kind_type;

   typedef struct {
      row_kind_type                           kind;
      logic [modexp_pkg::CSR_INDEX_WIDTH-1:0] index;
      word_type                               value;
      bit                                     typed;   // result typed in below
      word_type                               result;
   } row_type;

   // a result word still owed by the block
   typedef struct {
      int unsigned seq;
      word_type    base;
      word_type    power;
   } owed_power_type;

   logic                                   clock = 1'b0;
   logic                                   reset = 1'b1;
   logic                                   req_valid = 1'b0;
   logic                                   req_ready;
   word_type                               req_base_value = '0;
   logic                                   rsp_valid;
   logic                                   rsp_ready = 1'b0;
   word_type                               rsp_result_value;
   logic                                   csr_valid = 1'b0;
   logic                                   csr_ready;
   logic [modexp_pkg::CSR_INDEX_WIDTH-1:0] csr_index = modexp_pkg::CSR_EXPONENT;
   word_type                               csr_data = '0;

   // bench copy of the two registers, reset values of the block
   word_type       exponent_copy = word_type'(1);
   word_type       modulus_copy = word_type'(2);
   owed_power_type owed_powers[$];
   int unsigned    words_sent = 0;
   int unsigned    error_count = 0;
   int unsigned    cycle_count = 0;
   bit             no_gaps = 1'b0;   // phase with both sides running flat out

   // Directed table. After reset: exponent 1, modulus 2, so a result is the
   // parity of the base. Then zero exponent (0^0 too), largest modulus with
   // the largest exponent (base == modulus, base == -1 with odd exponent),
   // modulus one and zero, writes to unused indexes, and a small modulus.
   row_type plan [0:25] = '{
      '{ROW_BASE,  modexp_pkg::CSR_EXPONENT, 20'h00000, 1'b1, 20'h00000},
      '{ROW_BASE,  modexp_pkg::CSR_EXPONENT, 20'h00001, 1'b1, 20'h00001},
      '{ROW_BASE,  modexp_pkg::CSR_EXPONENT, 20'hFFFFF, 1'b1, 20'h00001},
      '{ROW_BASE,  modexp_pkg::CSR_EXPONENT, 20'hFFFFE, 1'b1, 20'h00000},
      '{ROW_WRITE, modexp_pkg::CSR_EXPONENT, 20'h00000, 1'b0, 20'h00000},
      '{ROW_BASE,  modexp_pkg::CSR_EXPONENT, 20'h00005, 1'b1, 20'h00001},
      '{ROW_BASE,  modexp_pkg::CSR_EXPONENT, 20'h00000, 1'b1, 20'h00001},
      '{ROW_WRITE, modexp_pkg::CSR_MODULUS,  20'hFFFFF, 1'b0, 20'h00000},
      '{ROW_BASE,  modexp_pkg::CSR_EXPONENT, 20'hFFFFF, 1'b1, 20'h00001},
      '{ROW_WRITE, modexp_pkg::CSR_EXPONENT, 20'hFFFFF, 1'b0, 20'h00000},
      '{ROW_BASE,  modexp_pkg::CSR_EXPONENT, 20'hFFFFF, 1'b1, 20'h00000},
      '{ROW_BASE,  modexp_pkg::CSR_EXPONENT, 20'hFFFFE, 1'b1, 20'hFFFFE},
      '{ROW_BASE,  modexp_pkg::CSR_EXPONENT, 20'h00002, 1'b0, 20'h00000},
      '{ROW_BASE,  modexp_pkg::CSR_EXPONENT, 20'h00000, 1'b1, 20'h00000},
      '{ROW_BASE,  modexp_pkg::CSR_EXPONENT, 20'h5A5A5, 1'b0, 20'h00000},
      '{ROW_WRITE, modexp_pkg::CSR_MODULUS,  20'h00001, 1'b0, 20'h00000},
      '{ROW_BASE,  modexp_pkg::CSR_EXPONENT, 20'h12345, 1'b1, 20'h00000},
      '{ROW_WRITE, modexp_pkg::CSR_MODULUS,  20'h00000, 1'b0, 20'h00000},
      '{ROW_BASE,  modexp_pkg::CSR_EXPONENT, 20'hFFFFF, 1'b1, 20'h00000},
      '{ROW_WRITE, CSR_SPARE_A,              20'h00007, 1'b0, 20'h00000},
      '{ROW_WRITE, CSR_SPARE_B,              20'h00000, 1'b0, 20'h00000},
      '{ROW_BASE,  modexp_pkg::CSR_EXPONENT, 20'h00003, 1'b1, 20'h00000},
      '{ROW_WRITE, modexp_pkg::CSR_MODULUS,  20'h00003, 1'b0, 20'h00000},
      '{ROW_BASE,  modexp_pkg::CSR_EXPONENT, 20'h00002, 1'b1, 20'h00002},
      '{ROW_WRITE, modexp_pkg::CSR_EXPONENT, 20'h00002, 1'b0, 20'h00000},
      '{ROW_BASE,  modexp_pkg::CSR_EXPONENT, 20'h00007, 1'b0, 20'h00000}
   };

   modular_exponentiation_top #(
      .WIDTH(WIDTH)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_base_value   (req_base_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_result_value (rsp_result_value),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // base^exponent mod modulus, MSB-first square and multiply; operands stay
   // below 2^20, so every product fits in 64 bits
   function automatic word_type mod_power(input word_type base, input word_type exponent,
                                          input word_type modulus);
      longint unsigned m;
      longint unsigned b;
      longint unsigned acc;
      if (modulus < 2)
         return '0;
      m = modulus;
      b = base % m;
      acc = 1;
      for (int i = WIDTH - 1; i >= 0; i--) begin
         acc = (acc * acc) % m;
         if (exponent[i])
            acc = (acc * b) % m;
      end
      return word_type'(acc);
   endfunction

   // idle length for either side: mostly none or short, now and then long
   function automatic int unsigned idle_cycles();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (no_gaps || r < 45)
         return 0;
      if (r < 92)
         return $urandom_range(1, 4);
      return $urandom_range(12, 60);
   endfunction

   task automatic report_mismatch(input string msg);
      $display("%0t ns mismatch: %s", $realtime, msg);
      error_count++;
   endtask

   // present one base word, hold it until taken, then record what it owes;
   // valid stays up when no gap follows, so back-to-back words stream
   task automatic send_base(input word_type base, input bit typed,
                            input word_type typed_result);
      int unsigned gap;
      owed_power_type owed;
      req_valid <= 1'b1;
      req_base_value <= base;
      do
         @(posedge clock);
      while (!req_ready);
      owed.seq = words_sent;
      owed.base = base;
      owed.power = typed ? typed_result : mod_power(base, exponent_copy, modulus_copy);
      owed_powers.insert(owed_powers.size(), owed);
      words_sent++;
      gap = idle_cycles();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // registers change only with the block idle: every owed word returned.
   // The owed queue is read at the falling edge, clear of the monitor's pop.
   task automatic write_register(input logic [modexp_pkg::CSR_INDEX_WIDTH-1:0] index,
                                 input word_type value);
      req_valid <= 1'b0;
      while (owed_powers.size() != 0)
         @(negedge clock);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      do
         @(posedge clock);
      while (!csr_ready);
      case (index)
         modexp_pkg::CSR_EXPONENT: exponent_copy = value;
         modexp_pkg::CSR_MODULUS:  modulus_copy = value;
         default: ;   // unused index, block keeps both registers
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic word_type pick_exponent();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return word_type'(1);
         2:       return word_type'(MAX_VALUE);
         3:       return word_type'(32'h10001);   // common public exponent
         4:       return word_type'($urandom_range(2, 255));
         default: return word_type'($urandom_range(0, MAX_VALUE));
      endcase
   endfunction

   function automatic word_type pick_modulus();
      case ($urandom_range(0, 11))
         0:       return word_type'(2);
         1:       return word_type'(MAX_VALUE);
         2:       return word_type'($urandom_range(0, 1));   // degenerate modulus
         3, 4:    return word_type'($urandom_range(3, 1000));
         default: return word_type'($urandom_range(2, MAX_VALUE));
      endcase
   endfunction

   function automatic word_type pick_base();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return word_type'(1);
         2:       return modulus_copy - word_type'(1);
         3:       return modulus_copy;
         4:       return word_type'(MAX_VALUE);
         default: return word_type'($urandom_range(0, MAX_VALUE));
      endcase
   endfunction

   // stimulus: reset, directed table, random phases, then drain
   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_WRITE)
            write_register(plan[i].index, plan[i].value);
         else
            send_base(plan[i].value, plan[i].typed, plan[i].result);
      end

      // each phase: new key pair, register order shuffled, the odd write to
      // an unused index, then a run of base words
      for (int unsigned phase = 0; phase < RANDOM_PHASES; phase++) begin
         no_gaps = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 1) == 1) begin
            write_register(modexp_pkg::CSR_EXPONENT, pick_exponent());
            write_register(modexp_pkg::CSR_MODULUS, pick_modulus());
         end else begin
            write_register(modexp_pkg::CSR_MODULUS, pick_modulus());
            write_register(modexp_pkg::CSR_EXPONENT, pick_exponent());
         end
         if ($urandom_range(0, 4) == 0)
            write_register($urandom_range(0, 1) ? CSR_SPARE_A : CSR_SPARE_B,
                           word_type'($urandom_range(0, MAX_VALUE)));
         for (int unsigned n = 0; n < WORDS_PER_PHASE; n++)
            send_base(pick_base(), 1'b0, '0);
      end

      req_valid <= 1'b0;
      while (owed_powers.size() != 0)
         @(negedge clock);
      // stray words after the last owed one still get flagged here
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("modular_exponentiation_top_tb: done, clean");
      else
         $display("modular_exponentiation_top_tb: done, errors");
      $finish;
   end

   // result side back-pressure, one assignment per edge
   initial begin : rsp_stall
      int unsigned stall;
      while (reset)
         @(posedge clock);
      forever begin
         stall = idle_cycles();
         if (stall == 0) begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end else begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
            rsp_ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // every returned word against the oldest owed one
   always @(posedge clock) begin : check_results
      owed_power_type head;
      if (!reset && rsp_valid && rsp_ready) begin
         if (owed_powers.size() == 0) begin
            report_mismatch($sformatf("result word %h with nothing owed", rsp_result_value));
         end else begin
            head = owed_powers.pop_front();
            if (rsp_result_value !== head.power)
               report_mismatch($sformatf("word %0d base %h: result %h, want %h",
                                         head.seq, head.base, rsp_result_value, head.power));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("modular_exponentiation_top_tb: done, errors");
         $finish;
      end
   end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/modexp_pkg.sv
hw/rtl/modexp_mulmod.sv
hw/rtl/modexp_reduce.sv
hw/rtl/modular_exponentiation_top.sv
bench/modular_exponentiation_top_tb.sv
